>>> design/kwus_pkg.sv
// ----------------------------------------------------------------------------
// kwus_pkg
// Shared types and constants for the Kruskal wall union step block.
// ----------------------------------------------------------------------------
package kwus_pkg;

  // Tile store geometry
  localparam int MAX_TILES = 4096;
  localparam int TILE_W    = $clog2(MAX_TILES);
  localparam int CNT_W     = TILE_W + 1;
  localparam int BUD_W     = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_BUDGET = 1'd1;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] TILES_RESET  = CNT_W'(MAX_TILES);
  localparam logic [BUD_W-1:0] BUDGET_RESET = '0;

  // Request modes
  localparam logic MODE_WALL    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B
  } kwus_state_t;

  // Budget control from sequencer to the budget counter
  typedef struct packed {
    logic budget_load;
    logic budget_dec;
  } kwus_ctl_t;

endpackage

>>> design/kwus_ram.sv
// ----------------------------------------------------------------------------
// kwus_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kwus_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/kwus_seq.sv
// ----------------------------------------------------------------------------
// kwus_seq
// Sequencer: clearing pass, two root walks through the parent store, and the
// join or budget decision. Drives the result registers.
// ----------------------------------------------------------------------------
module kwus_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         in_mode,
  input  logic [kwus_pkg::TILE_W-1:0]  in_tile_a,
  input  logic [kwus_pkg::TILE_W-1:0]  in_tile_b,
  input  logic [kwus_pkg::CNT_W-1:0]   tiles_in_use,
  input  logic                         budget_nz,
  output logic                         busy,
  output kwus_pkg::kwus_ctl_t          ctl,
  output logic                         ram_we,
  output logic [kwus_pkg::TILE_W-1:0]  ram_wr_addr,
  output logic [kwus_pkg::TILE_W-1:0]  ram_wr_data,
  output logic [kwus_pkg::TILE_W-1:0]  ram_rd_addr,
  input  logic [kwus_pkg::TILE_W-1:0]  ram_rd_data,
  output logic                         out_valid,
  output logic                         out_remove_wall,
  output logic                         out_joined,
  output logic                         out_bad_tile
);
  import kwus_pkg::*;

  kwus_state_t       state_r, state_nxt;
  logic [TILE_W-1:0] cur_r, cur_nxt;     // node being walked
  logic [TILE_W-1:0] ra_r, ra_nxt;       // root of tile a
  logic [TILE_W-1:0] b_r, b_nxt;         // held tile b
  logic [TILE_W-1:0] clr_r, clr_nxt;     // clearing pass address
  logic              emit_r, emit_nxt;   // clearing pass answers a restart
  logic              valid_r, valid_nxt;
  logic              remove_r, remove_nxt;
  logic              joined_r, joined_nxt;
  logic              bad_r, bad_nxt;
  logic              tile_bad;
  logic              at_root;

  // Range check against the tile count (a count above the store size never trips)
  assign tile_bad = ({1'b0, in_tile_a} >= tiles_in_use) ||
                    ({1'b0, in_tile_b} >= tiles_in_use);

  // Read data is the parent of the node read last cycle
  assign at_root = (ram_rd_data == cur_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      emit_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      emit_r  <= emit_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    ra_r     <= ra_nxt;
    b_r      <= b_nxt;
    remove_r <= remove_nxt;
    joined_r <= joined_nxt;
    bad_r    <= bad_nxt;
  end

  // Next state and outputs
  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    ra_nxt      = ra_r;
    b_nxt       = b_r;
    clr_nxt     = clr_r;
    emit_nxt    = emit_r;
    valid_nxt   = 1'b0;
    remove_nxt  = 1'b0;
    joined_nxt  = 1'b0;
    bad_nxt     = 1'b0;
    ctl         = '0;
    ram_we      = 1'b0;
    ram_wr_addr = clr_r;
    ram_wr_data = clr_r;
    ram_rd_addr = cur_r;
    case (state_r)
      ST_CLEAR: begin
        // each entry points to itself
        ram_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TILE_W'(MAX_TILES - 1)) begin
          state_nxt = ST_IDLE;
          valid_nxt = emit_r;
          emit_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_RESTART) begin
            ctl.budget_load = 1'b1;
            clr_nxt         = '0;
            emit_nxt        = 1'b1;
            state_nxt       = ST_CLEAR;
          end else if (tile_bad) begin
            valid_nxt = 1'b1;
            bad_nxt   = 1'b1;
          end else begin
            ram_rd_addr = in_tile_a;
            cur_nxt     = in_tile_a;
            b_nxt       = in_tile_b;
            state_nxt   = ST_WALK_A;
          end
        end
      end
      ST_WALK_A: begin
        if (at_root) begin
          ra_nxt      = cur_r;
          cur_nxt     = b_r;
          ram_rd_addr = b_r;
          state_nxt   = ST_WALK_B;
        end else begin
          cur_nxt     = ram_rd_data;
          ram_rd_addr = ram_rd_data;
        end
      end
      ST_WALK_B: begin
        if (at_root) begin
          state_nxt = ST_IDLE;
          valid_nxt = 1'b1;
          if (ra_r != cur_r) begin
            // join: root of a now hangs under root of b
            ram_we      = 1'b1;
            ram_wr_addr = ra_r;
            ram_wr_data = cur_r;
            remove_nxt  = 1'b1;
            joined_nxt  = 1'b1;
          end else if (budget_nz) begin
            remove_nxt     = 1'b1;
            ctl.budget_dec = 1'b1;
          end
        end else begin
          cur_nxt     = ram_rd_data;
          ram_rd_addr = ram_rd_data;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = valid_r;
  assign out_remove_wall = remove_r;
  assign out_joined      = joined_r;
  assign out_bad_tile    = bad_r;

endmodule

>>> design/kruskal_wall_union_step_top.sv
// ----------------------------------------------------------------------------
// kruskal_wall_union_step_top
// Union step of a randomised Kruskal maze builder over a disjoint-set store.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge with start high and busy low. A wall
//   request (in_mode 0) names two tiles; a restart request (in_mode 1) makes
//   every tile its own set and reloads the removal budget.
//   Each request gives one result, shown for one cycle with out_valid high;
//   the receiver cannot stall it, so it must take it then.
//   A wall request walks tile a and then tile b up to their roots through
//   the single read port of the parent RAM; each parent link from a tile to
//   its root costs one read of that RAM.
//   An out-of-range tile answers in the next cycle with no store access.
//   A restart runs a clearing pass over all 4096 entries.
//   After reset the same clearing pass runs (busy high, no result);
//   configuration writes are taken at any time.
//   The budget register takes effect at the next restart.
// ----------------------------------------------------------------------------
module kruskal_wall_union_step_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_mode,
  input  logic [kwus_pkg::TILE_W-1:0]      in_tile_a,
  input  logic [kwus_pkg::TILE_W-1:0]      in_tile_b,
  output logic                             out_valid,
  output logic                             out_remove_wall,
  output logic                             out_joined,
  output logic                             out_bad_tile,
  input  logic                             cfg_we,
  input  logic [kwus_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kwus_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kwus_pkg::*;

  logic [CNT_W-1:0]  tiles_r;
  logic [BUD_W-1:0]  budget_cfg_r;
  logic [BUD_W-1:0]  budget_r, budget_nxt;
  kwus_ctl_t         ctl;
  logic              ram_we;
  logic [TILE_W-1:0] ram_wr_addr;
  logic [TILE_W-1:0] ram_wr_data;
  logic [TILE_W-1:0] ram_rd_addr;
  logic [TILE_W-1:0] ram_rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_r      <= TILES_RESET;
      budget_cfg_r <= BUDGET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TILES_IN_USE: tiles_r      <= cfg_data;
        CFG_EXTRA_BUDGET: budget_cfg_r <= cfg_data[BUD_W-1:0];
        default: ;
      endcase
    end
  end

  // Removal budget counter
  always_comb begin
    budget_nxt = budget_r;
    if (ctl.budget_load) begin
      budget_nxt = budget_cfg_r;
    end else if (ctl.budget_dec) begin
      budget_nxt = budget_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= '0;
    end else begin
      budget_r <= budget_nxt;
    end
  end

  // Parent store
  kwus_ram #(
    .WIDTH (TILE_W),
    .DEPTH (MAX_TILES)
  ) u_parent (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Walk sequencer
  kwus_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_mode         (in_mode),
    .in_tile_a       (in_tile_a),
    .in_tile_b       (in_tile_b),
    .tiles_in_use    (tiles_r),
    .budget_nz       (budget_r != '0),
    .busy            (busy),
    .ctl             (ctl),
    .ram_we          (ram_we),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .out_valid       (out_valid),
    .out_remove_wall (out_remove_wall),
    .out_joined      (out_joined),
    .out_bad_tile    (out_bad_tile)
  );

endmodule
